[hw/rtl/bpf_pkg.sv]
package bpf_pkg;

	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_ROLL  = 2'd1;
	localparam logic [1:0] FUNC_PATH  = 2'd2;
	localparam logic [1:0] FUNC_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;
	localparam logic [1:0] ST_LABEL = 2'd3;

	localparam int NODE_W  = 6;
	localparam int DEPTH_W = 11;
	localparam int OUT_LABEL_W = 16;

endpackage

[hw/rtl/backtrackable_proof_forest_unit.sv]
// channel | signals                                   | handshake
// command | func node_a node_b snapshot               | start high while busy low
// result  | label trail_depth status last             | strobe, one cycle, no stall
// an add edge walks both nodes to their roots, re-roots node_a and hangs it under node_b;
// a rollback undoes trail words down to the snapshot; a path query walks the nodes, sends
// one word per path edge and then clears the marks; table reads are registered
// after reset and after clear all a pass over the table sets every node to its own root
// the receiver cannot stall; strobe marks each result word
module backtrackable_proof_forest_unit #(
	parameter int NODES       = 64,
	parameter int TRAIL_DEPTH = 1024,
	parameter int LABEL_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        func,
	input  logic [bpf_pkg::NODE_W-1:0]        node_a,
	input  logic [bpf_pkg::NODE_W-1:0]        node_b,
	input  logic [bpf_pkg::DEPTH_W-1:0]       snapshot,
	output logic                              strobe,
	output logic [bpf_pkg::OUT_LABEL_W-1:0]   label,
	output logic [bpf_pkg::DEPTH_W-1:0]       trail_depth,
	output logic [1:0]                        status,
	output logic                              last
);
	import bpf_pkg::*;

	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int TW = $clog2(TRAIL_DEPTH);
	localparam int CW = TW + 1;
	localparam int LW = LABEL_BITS;

	localparam logic [4:0] S_INIT   = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_RA     = 5'd2;
	localparam logic [4:0] S_RB     = 5'd3;
	localparam logic [4:0] S_CHK    = 5'd4;
	localparam logic [4:0] S_MR0    = 5'd5;
	localparam logic [4:0] S_MR     = 5'd6;
	localparam logic [4:0] S_HANG   = 5'd7;
	localparam logic [4:0] S_RB0    = 5'd8;
	localparam logic [4:0] S_RB1    = 5'd9;
	localparam logic [4:0] S_RB2    = 5'd10;
	localparam logic [4:0] S_MK     = 5'd11;
	localparam logic [4:0] S_FV     = 5'd12;
	localparam logic [4:0] S_EU     = 5'd13;
	localparam logic [4:0] S_EV     = 5'd14;
	localparam logic [4:0] S_UNMK   = 5'd15;
	localparam logic [4:0] S_ONE    = 5'd17;

	logic [4:0] state_q;

	// tables in flops, read through one registered port at cur_q
	logic [NW-1:0] par_q [NODES];
	logic [LW-1:0] lab_q [NODES];
	logic          mark_q [NODES];
	logic [NW-1:0] par_rd_q;
	logic [LW-1:0] lab_rd_q;
	logic          mark_rd_q;
	logic          ph_q;

	logic [NW+NW+LW-1:0] trail_mem [TRAIL_DEPTH];
	logic [NW+NW+LW-1:0] trail_rd_q;

	logic [CW-1:0] cnt_q;
	logic [LW:0]   nl_q;
	logic [1:0]    func_q;
	logic [NW-1:0] u_q, v_q, cur_q, np_q, nca_q, walk_q, rootu_q;
	logic [LW-1:0] lab_hold_q, newl_q;
	logic [CW-1:0] snap_q;
	logic [NW:0]   step_q;
	logic          range_bad_q;
	logic [6:0]    k_q;
	logic          leg_q;

	logic          strobe_q, last_q;
	logic [1:0]    status_q;
	logic [OUT_LABEL_W-1:0] label_q;
	logic [1:0]    one_st_q;
	logic [LW-1:0] one_lab_q;

	logic [NW-1:0] pc;
	logic [LW-1:0] lc;
	logic          write_en;
	logic [NW-1:0] w_node, w_par, w_opar;
	logic [LW-1:0] w_lab, w_olab;
	logic          log_en;

	assign pc = par_rd_q;
	assign lc = lab_rd_q;

	assign busy = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign last = last_q;
	assign status = status_q;
	assign label = label_q;
	assign trail_depth = DEPTH_W'(cnt_q);

	// table write port: one parent/label write per cycle, logged or not
	always_comb begin
		write_en = 1'b0;
		log_en = 1'b0;
		w_node = cur_q;
		w_par = np_q;
		w_lab = lab_hold_q;
		w_opar = pc;
		w_olab = lc;
		unique case (state_q)
			S_MR0: begin
				write_en = ph_q; log_en = ph_q;
				w_node = u_q; w_par = u_q; w_lab = '0;
			end
			S_MR: begin
				write_en = ph_q; log_en = ph_q;
			end
			S_HANG: begin
				write_en = 1'b1; log_en = 1'b1;
				w_node = u_q; w_par = v_q; w_lab = newl_q;
				w_opar = u_q; w_olab = '0;
			end
			S_RB2: begin
				write_en = 1'b1;
				w_node = trail_rd_q[NW+NW+LW-1 -: NW];
				w_par = trail_rd_q[NW+LW-1 -: NW];
				w_lab = trail_rd_q[LW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (log_en && cnt_q < CW'(TRAIL_DEPTH))
			trail_mem[cnt_q[TW-1:0]] <= {w_node, w_opar, w_olab};
		trail_rd_q <= trail_mem[TW'(cnt_q - CW'(1))];
		par_rd_q <= par_q[cur_q];
		lab_rd_q <= lab_q[cur_q];
		mark_rd_q <= mark_q[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			step_q <= '0;
			cnt_q <= '0;
			nl_q <= '0;
			strobe_q <= 1'b0;
			ph_q <= 1'b0;
			for (int i = 0; i < NODES; i++) mark_q[i] <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (write_en) begin
				par_q[w_node] <= w_par;
				lab_q[w_node] <= w_lab;
				if (log_en && cnt_q < CW'(TRAIL_DEPTH)) cnt_q <= cnt_q + CW'(1);
			end
			unique case (state_q)
				S_INIT: begin
					par_q[step_q[NW-1:0]] <= step_q[NW-1:0];
					lab_q[step_q[NW-1:0]] <= '0;
					mark_q[step_q[NW-1:0]] <= 1'b0;
					if (step_q == (NW+1)'(NODES - 1)) state_q <= S_IDLE;
					step_q <= step_q + 1'b1;
				end
				S_IDLE: if (start) begin
					func_q <= func;
					u_q <= NW'(node_a);
					v_q <= NW'(node_b);
					snap_q <= CW'(snapshot);
					range_bad_q <= (32'(node_a) >= NODES) || (32'(node_b) >= NODES);
					cur_q <= NW'(node_a);
					step_q <= '0;
					ph_q <= 1'b0;
					one_lab_q <= '0;
					one_st_q <= ST_OK;
					unique case (func)
						FUNC_ADD:  state_q <= S_RA;
						FUNC_ROLL: state_q <= S_RB0;
						FUNC_PATH: state_q <= S_MK;
						default: begin
							step_q <= '0;
							cnt_q <= '0;
							nl_q <= '0;
							state_q <= S_INIT;
							strobe_q <= 1'b1; last_q <= 1'b1;
							status_q <= ST_OK; label_q <= '0;
						end
					endcase
				end
				S_RA: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (pc == cur_q || step_q == (NW+1)'(NODES - 1)) begin
							rootu_q <= (pc == cur_q) ? cur_q : pc;
							cur_q <= v_q; step_q <= '0; state_q <= S_RB;
						end else begin
							cur_q <= pc; step_q <= step_q + 1'b1;
						end
					end
				end
				S_RB: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (pc == cur_q || step_q == (NW+1)'(NODES - 1)) begin
							walk_q <= (pc == cur_q) ? cur_q : pc;
							state_q <= S_CHK;
						end else begin
							cur_q <= pc; step_q <= step_q + 1'b1;
						end
					end
				end
				S_CHK: begin
					state_q <= S_ONE;
					if (range_bad_q) one_st_q <= ST_NONE;
					else if (32'(TRAIL_DEPTH) - 32'(cnt_q) < 32'(NODES) + 1)
						one_st_q <= ST_FULL;
					else if (nl_q[LW]) one_st_q <= ST_LABEL;
					else if (u_q == v_q || rootu_q == walk_q) one_st_q <= ST_NONE;
					else begin
						newl_q <= nl_q[LW-1:0];
						nl_q <= nl_q + 1'b1;
						cur_q <= u_q;
						state_q <= S_MR0;
					end
				end
				S_MR0: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						// u: parent and label read before the write lands
						lab_hold_q <= lc;
						np_q <= u_q;
						cur_q <= pc;
						step_q <= '0;
						state_q <= (pc == u_q) ? S_HANG : S_MR;
					end
				end
				S_MR: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						np_q <= cur_q;
						lab_hold_q <= lc;
						cur_q <= pc;
						step_q <= step_q + 1'b1;
						if (pc == cur_q || step_q == (NW+1)'(NODES - 1)) state_q <= S_HANG;
					end
				end
				S_HANG: begin
					one_lab_q <= newl_q;
					state_q <= S_ONE;
				end
				S_RB0: begin
					if (cnt_q > snap_q && cnt_q != '0) state_q <= S_RB1;
					else state_q <= S_ONE;
				end
				S_RB1: state_q <= S_RB2;
				S_RB2: begin
					cnt_q <= cnt_q - CW'(1);
					state_q <= S_RB0;
				end
				S_MK: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (range_bad_q || u_q == v_q) begin
							one_st_q <= ST_NONE; state_q <= S_ONE;
						end else begin
							mark_q[cur_q] <= 1'b1;
							if (pc == cur_q || step_q == (NW+1)'(NODES - 1)) begin
								cur_q <= v_q; step_q <= '0; state_q <= S_FV;
							end else begin
								cur_q <= pc; step_q <= step_q + 1'b1;
							end
						end
					end
				end
				S_FV: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (mark_rd_q) begin
							nca_q <= cur_q; cur_q <= u_q; k_q <= '0; leg_q <= 1'b0;
							state_q <= S_EU;
						end else if (pc == cur_q || step_q == (NW+1)'(NODES - 1)) begin
							one_st_q <= ST_NONE; cur_q <= u_q; step_q <= '0;
							k_q <= '0; state_q <= S_UNMK;
						end else begin
							cur_q <= pc; step_q <= step_q + 1'b1;
						end
					end
				end
				S_EU, S_EV: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (cur_q != nca_q && k_q < 7'd63) begin
							// each word goes out once the next one is known
							if (k_q != '0) begin
								strobe_q <= 1'b1; last_q <= 1'b0;
								status_q <= ST_OK; label_q <= OUT_LABEL_W'(one_lab_q);
							end
							one_lab_q <= lc;
							k_q <= k_q + 1'b1;
							cur_q <= pc;
						end else if (state_q == S_EU) begin
							cur_q <= v_q; state_q <= S_EV;
						end else begin
							step_q <= '0; state_q <= S_UNMK;
						end
					end
				end
				S_UNMK: begin
					mark_q[step_q[NW-1:0]] <= 1'b0;
					step_q <= step_q + 1'b1;
					if (step_q == (NW+1)'(NODES - 1)) begin
						if (k_q == '0) one_st_q <= ST_NONE;
						state_q <= S_ONE;
					end
				end
				S_ONE: begin
					strobe_q <= 1'b1; last_q <= 1'b1;
					status_q <= one_st_q; label_q <= OUT_LABEL_W'(one_lab_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy || start)) else $error("word without work");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TRAIL_DEPTH)) else $error("trail overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !strobe_q || last_q) else $error("open run");
endmodule

[bench/backtrackable_proof_forest_unit_tb.sv]
`timescale 1ns / 1ps

import bpf_pkg::*;

typedef struct packed {
	logic [15:0] label;
	logic [10:0] depth;
	logic [1:0]  status;
	logic        last;
} forest_word_t;

class forest_scoreboard;
	logic [5:0]  parent_of [64];
	logic [15:0] edge_label [64];
	logic [5:0]  undo_node [1024];
	logic [5:0]  undo_parent [1024];
	logic [15:0] undo_label [1024];
	int unsigned undo_depth;
	logic [16:0] label_count;
	forest_word_t expected_words [$];
	int errors;
	int words_seen;
	int items_by_func [4];
	int refusals;

	function void clear_forest();
		for (int i = 0; i < 64; i++) begin
			parent_of[i] = i;
			edge_label[i] = '0;
		end
		undo_depth = 0;
		label_count = '0;
	endfunction

	function new();
		clear_forest();
		errors = 0;
		words_seen = 0;
		refusals = 0;
		foreach (items_by_func[i]) items_by_func[i] = 0;
	endfunction

	function int unsigned root_of(int unsigned n);
		for (int i = 0; i < 64; i++) begin
			if (parent_of[n] == n) break;
			n = parent_of[n];
		end
		return n;
	endfunction

	function int unsigned depth_of(int unsigned n);
		int unsigned d;
		d = 0;
		for (int i = 0; i < 64; i++) begin
			if (parent_of[n] == n) break;
			n = parent_of[n];
			d++;
		end
		return d;
	endfunction

	function void relink(int unsigned n, int unsigned np, logic [15:0] nl);
		if (undo_depth < 1024) begin
			undo_node[undo_depth] = n;
			undo_parent[undo_depth] = parent_of[n];
			undo_label[undo_depth] = edge_label[n];
			undo_depth++;
		end
		parent_of[n] = np;
		edge_label[n] = nl;
	endfunction

	function void reroot(int unsigned u);
		int unsigned p1, cur, np, oldp;
		logic [15:0] lab, oldl;
		p1 = parent_of[u];
		lab = edge_label[u];
		relink(u, u, '0);
		if (p1 == u) return;
		cur = p1;
		np = u;
		for (int i = 0; i < 64; i++) begin
			oldp = parent_of[cur];
			oldl = edge_label[cur];
			relink(cur, np, lab);
			if (oldp == cur) break;
			np = cur;
			lab = oldl;
			cur = oldp;
		end
	endfunction

	function void push_word(logic [15:0] lab, logic [1:0] st, logic lst);
		forest_word_t w;
		w.label = lab;
		w.depth = undo_depth[10:0];
		w.status = st;
		w.last = lst;
		expected_words.insert(expected_words.size(), w);
	endfunction

	function void note(logic [1:0] f, logic [5:0] u, logic [5:0] v, logic [10:0] snap);
		bit marks [64];
		int unsigned c, meet, k;
		bit found;
		logic [15:0] lab;
		items_by_func[f]++;
		case (f)
			FUNC_ADD: begin
				if (1024 - undo_depth < 65) begin
					push_word('0, ST_FULL, 1'b1);
					refusals++;
				end else if (label_count >= 17'h10000) begin
					push_word('0, ST_LABEL, 1'b1);
					refusals++;
				end else if (u == v || root_of(u) == root_of(v)) begin
					push_word('0, ST_NONE, 1'b1);
					refusals++;
				end else begin
					lab = label_count[15:0];
					label_count++;
					reroot(u);
					relink(u, v, lab);
					push_word(lab, ST_OK, 1'b1);
				end
			end
			FUNC_ROLL: begin
				while (undo_depth > snap && undo_depth > 0) begin
					undo_depth--;
					parent_of[undo_node[undo_depth]] = undo_parent[undo_depth];
					edge_label[undo_node[undo_depth]] = undo_label[undo_depth];
				end
				push_word('0, ST_OK, 1'b1);
			end
			FUNC_PATH: begin
				if (u == v) begin
					push_word('0, ST_NONE, 1'b1);
					return;
				end
				foreach (marks[i]) marks[i] = 0;
				c = u;
				for (int i = 0; i < 64; i++) begin
					marks[c] = 1;
					if (parent_of[c] == c) break;
					c = parent_of[c];
				end
				found = 0;
				meet = 0;
				c = v;
				for (int i = 0; i < 64; i++) begin
					if (marks[c]) begin
						meet = c;
						found = 1;
						break;
					end
					if (parent_of[c] == c) break;
					c = parent_of[c];
				end
				if (!found) begin
					push_word('0, ST_NONE, 1'b1);
					return;
				end
				k = 0;
				for (c = u; c != meet && k < 63; c = parent_of[c]) begin
					push_word(edge_label[c], ST_OK, 1'b0);
					k++;
				end
				for (c = v; c != meet && k < 63; c = parent_of[c]) begin
					push_word(edge_label[c], ST_OK, 1'b0);
					k++;
				end
				if (k == 0) push_word('0, ST_NONE, 1'b1);
				else expected_words[$].last = 1'b1;
			end
			default: begin
				clear_forest();
				push_word('0, ST_OK, 1'b1);
			end
		endcase
	endfunction

	function void check(forest_word_t got);
		forest_word_t w;
		words_seen++;
		if (expected_words.size() == 0) begin
			$display("%0t: unexpected result word label=%0d depth=%0d status=%0d last=%0d",
				$time, got.label, got.depth, got.status, got.last);
			errors++;
			return;
		end
		w = expected_words.pop_front();
		if (got.label !== w.label) begin
			$display("%0t: label expected %0d actual %0d", $time, w.label, got.label);
			errors++;
		end
		if (got.depth !== w.depth) begin
			$display("%0t: trail_depth expected %0d actual %0d", $time, w.depth, got.depth);
			errors++;
		end
		if (got.status !== w.status) begin
			$display("%0t: status expected %0d actual %0d", $time, w.status, got.status);
			errors++;
		end
		if (got.last !== w.last) begin
			$display("%0t: last expected %0d actual %0d", $time, w.last, got.last);
			errors++;
		end
	endfunction
endclass

module backtrackable_proof_forest_unit_tb;
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] func;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;
	logic [DEPTH_W-1:0] snapshot;
	logic strobe;
	logic [OUT_LABEL_W-1:0] label;
	logic [DEPTH_W-1:0] trail_depth;
	logic [1:0] status;
	logic last;

	forest_scoreboard sb;
	int idle_cycles;

	backtrackable_proof_forest_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .node_a(node_a), .node_b(node_b), .snapshot(snapshot),
		.strobe(strobe), .label(label), .trail_depth(trail_depth),
		.status(status), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check({label, trail_depth, status, last});
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 20000) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send(logic [1:0] f, logic [5:0] u, logic [5:0] v, logic [10:0] snap);
		int gap;
		gap = $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		node_a <= u;
		node_b <= v;
		snapshot <= snap;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note(f, u, v, snap);
	endtask

	task automatic random_item();
		int r;
		logic [10:0] snap;
		r = $urandom_range(0, 99);
		if (sb.undo_depth > 900 && r < 60) r = 70;
		if (r < 45) begin
			send(FUNC_ADD, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
		end else if (r < 70) begin
			send(FUNC_PATH, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
		end else if (r < 97) begin
			if ($urandom_range(0, 4) == 0) snap = $urandom_range(0, 2047);
			else snap = $urandom_range(0, sb.undo_depth);
			send(FUNC_ROLL, $urandom, $urandom, snap);
		end else begin
			send(FUNC_CLEAR, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		int deepest;
		sb = new();
		idle_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_CLEAR;
		node_a = '0;
		node_b = '0;
		snapshot = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send(FUNC_PATH, 6'd3, 6'd3, 11'd0);
		send(FUNC_PATH, 6'd0, 6'd63, 11'd0);
		send(FUNC_ADD, 6'd5, 6'd5, 11'd0);
		send(FUNC_ADD, 6'd0, 6'd63, 11'd0);
		send(FUNC_PATH, 6'd63, 6'd0, 11'd0);
		send(FUNC_ADD, 6'd63, 6'd0, 11'd0);
		send(FUNC_ROLL, 6'd0, 6'd0, 11'h7ff);
		send(FUNC_ROLL, 6'd0, 6'd0, 11'd0);
		// long re-rooting chains until the trail fills up
		for (int i = 1; i < 64; i++) begin
			deepest = 0;
			for (int j = 1; j < i; j++)
				if (sb.depth_of(j) > sb.depth_of(deepest)) deepest = j;
			send(FUNC_ADD, deepest, i, 11'd0);
		end
		send(FUNC_PATH, 6'd0, 6'd63, 11'd0);
		send(FUNC_PATH, 6'd17, 6'd42, 11'd0);
		send(FUNC_ROLL, 6'd0, 6'd0, 11'd400);
		send(FUNC_PATH, 6'd1, 6'd62, 11'd0);
		send(FUNC_CLEAR, 6'd63, 6'd63, 11'h7ff);

		for (int n = 0; n < 175; n++) random_item();

		start <= 1'b0;
		while (sb.expected_words.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("covered %0d adds (%0d refused), %0d rollbacks, %0d path queries, %0d clears",
			sb.items_by_func[FUNC_ADD], sb.refusals, sb.items_by_func[FUNC_ROLL],
			sb.items_by_func[FUNC_PATH], sb.items_by_func[FUNC_CLEAR]);
		$display("checked %0d result words", sb.words_seen);
		if (sb.errors == 0 && sb.expected_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

[sim.f]
hw/rtl/bpf_pkg.sv
hw/rtl/backtrackable_proof_forest_unit.sv
bench/backtrackable_proof_forest_unit_tb.sv
